// ===== rtl/svoice_pkg.sv =====
`timescale 1ns / 1ps

package svoice_pkg;

  // Default build values
  localparam int DEF_SINE_TABLE_DEPTH = 1024;
  localparam int DEF_PHASE_BITS       = 32;
  localparam int DEF_SAMPLE_BITS      = 16;

  // Field widths
  localparam int SR_W    = 18;
  localparam int CMD_W   = 2;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int BASE_W  = 20;   // Q16 frequency of the lowest octave
  localparam int FREQ_W  = 30;   // base shifted left by up to ten octaves
  localparam int OCT_W   = 4;
  localparam int LEVEL_W = 14;   // level never exceeds 9830
  localparam int GAIN_W  = 17;   // Q1.16 gain, 65536 is unity
  localparam int Q30_W   = 31;   // Q30 values in [0, 1]

  localparam logic [SR_W-1:0] SR_RESET = 18'd48000;

  // Commands
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

  // Release envelope
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
  localparam logic [15:0]       DECAY_Q16  = 16'd64881;
  localparam logic [GAIN_W-1:0] STOP_FLOOR = 17'd327;

  // Level = round(velocity * 98304 / 1270)
  localparam int                   LVL_NUM_W   = 24;
  localparam logic [LVL_NUM_W-1:0] LVL_SCALE   = 24'd98304;
  localparam logic [LVL_NUM_W-1:0] LVL_BIAS    = 24'd635;
  localparam logic [SR_W-1:0]      LVL_DIVISOR = 18'd1270;

  // Divide by 1270 as a multiply by ceil(2^35 / 1270), exact for 24-bit numerators
  localparam int                 LVL_SHIFT = 35;
  localparam logic [LVL_NUM_W:0] LVL_RECIP = 25'd27054913;

  // Quarter-wave sine polynomial in Q30
  localparam logic [Q30_W-1:0] Q30_ONE = 31'd1073741824;
  localparam logic [Q30_W-1:0] POLY_C0 = 31'd172271;
  localparam logic [Q30_W-1:0] POLY_C1 = 31'd5026995;
  localparam logic [Q30_W-1:0] POLY_C2 = 31'd85569306;
  localparam logic [Q30_W-1:0] POLY_C3 = 31'd693598670;
  localparam logic [Q30_W-1:0] POLY_C4 = 31'd1686629713;

  // Q16 frequency of pitch classes 0..11 in the lowest octave
  function automatic logic [BASE_W-1:0] octave_base(input logic [OCT_W-1:0] pc);
    logic [BASE_W-1:0] f;
    case (pc)
      4'd0:    f = 20'd535809;
      4'd1:    f = 20'd567670;
      4'd2:    f = 20'd601425;
      4'd3:    f = 20'd637188;
      4'd4:    f = 20'd675077;
      4'd5:    f = 20'd715219;
      4'd6:    f = 20'd757749;
      4'd7:    f = 20'd802807;
      4'd8:    f = 20'd850544;
      4'd9:    f = 20'd901120;
      4'd10:   f = 20'd954703;
      4'd11:   f = 20'd1011473;
      default: f = 20'd535809;
    endcase
    return f;
  endfunction

  // note / 12 as note * 171 >> 11, exact for 7-bit notes
  function automatic logic [OCT_W-1:0] note_octave(input logic [NOTE_W-1:0] n);
    logic [14:0] prod;
    prod = 15'(n) * 15'd171;
    return prod[14:11];
  endfunction

  // note % 12 from the octave
  function automatic logic [OCT_W-1:0] note_class(input logic [NOTE_W-1:0] n,
                                                  input logic [OCT_W-1:0]  oct);
    logic [NOTE_W-1:0] d;
    d = n - 7'(oct) * 7'd12;
    return d[OCT_W-1:0];
  endfunction

endpackage

// ===== rtl/svoice_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The caller picks the number
// of steps; the top `steps` bits of the dividend are consumed MSB first and
// the quotient appears in the low bits.
module svoice_div #(
  parameter int DIVIDEND_W = 47,
  parameter int DIVISOR_W  = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [DIVIDEND_W-1:0]             dividend,
  input  logic [DIVISOR_W-1:0]              divisor,
  input  logic [$clog2(DIVIDEND_W+1)-1:0]   steps,
  output logic                              done,
  output logic [DIVIDEND_W-1:0]             quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_r,  rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r,  quo_nxt;
  logic [DIVISOR_W-1:0]  dsr_r,  dsr_nxt;
  logic [CNT_W-1:0]      cnt_r,  cnt_nxt;
  logic                  done_r, done_nxt;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  // Trial subtract of the shifted remainder
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dsr_nxt = divisor;
      cnt_nxt = steps;
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt  = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/svoice_mul.sv =====
`timescale 1ns / 1ps

// Shared multiplier with a registered product
module svoice_mul #(
  parameter int A_W = 31,
  parameter int B_W = 31
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  logic [A_W+B_W-1:0] p_r, p_nxt;

  assign p_nxt = (A_W + B_W)'(a) * (A_W + B_W)'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

// ===== rtl/sine_voice_with_tail_off.sv =====
`timescale 1ns / 1ps

// One sine voice with an exponential release.
// Channels: cfg_* writes the sample rate (always ready). in_* takes one item:
// note on, note off (with or without tail-off) or a render tick. out_* gives
// one item per tick: the signed sample and whether the voice was sounding.
// A note off is handled in the idle state. A note on keeps in_ready low
// while the bit-serial divider forms the phase step (PHASE_BITS + 15
// steps); the shared multiplier scales the level meanwhile.
// A tick's result becomes valid in the same cycle as in_ready returns, after
// the sixteen micro-steps that reuse one registered multiplier for the sine
// polynomial, the level and gain scaling, and the release decay.
// in_ready is high only while the sequencer is idle. A finished result sits in
// the output register; a new item is taken while it waits, but a following
// tick holds in its last step until the receiver takes the earlier result.
// Reset (synchronous, rst_n low) silences the voice, sets the sample rate to
// 48000 and empties the output register.
module sine_voice_with_tail_off #(
  parameter int SINE_TABLE_DEPTH = svoice_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int PHASE_BITS       = svoice_pkg::DEF_PHASE_BITS,
  parameter int SAMPLE_BITS      = svoice_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [svoice_pkg::SR_W-1:0]           cfg_sample_rate_hz,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [svoice_pkg::CMD_W-1:0]          in_cmd,
  input  logic [svoice_pkg::NOTE_W-1:0]         in_note,
  input  logic [svoice_pkg::VEL_W-1:0]          in_velocity,
  input  logic                                  in_allow_tail_off,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]         out_sample,
  output logic                                  out_active
);

  import svoice_pkg::*;

  localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int NUM_W    = FREQ_W + PHASE_BITS - 16;
  localparam int DIV_W    = NUM_W + 1;
  localparam int CNT_W    = $clog2(DIV_W + 1);
  localparam int MA_W     = (SAMPLE_BITS + 13 > Q30_W) ? SAMPLE_BITS + 13 : Q30_W;
  localparam int MB_W     = Q30_W;
  localparam int MP_W     = MA_W + MB_W;
  localparam int MAG_W    = SAMPLE_BITS - 1;
  localparam int SUM_W    = Q30_W + 1;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_NOTE  = 4'b0010,
    S_DSTEP = 4'b0100,
    S_TICK  = 4'b1000
  } state_t;

  // Tick micro-steps
  localparam logic [3:0] T_SQ  = 4'd0;   // x * x
  localparam logic [3:0] T_X2  = 4'd1;   // hold x^2
  localparam logic [3:0] T_M0  = 4'd2;
  localparam logic [3:0] T_S1  = 4'd3;
  localparam logic [3:0] T_M1  = 4'd4;
  localparam logic [3:0] T_S2  = 4'd5;
  localparam logic [3:0] T_M2  = 4'd6;
  localparam logic [3:0] T_S3  = 4'd7;
  localparam logic [3:0] T_M3  = 4'd8;
  localparam logic [3:0] T_S4  = 4'd9;
  localparam logic [3:0] T_MX  = 4'd10;  // x * poly
  localparam logic [3:0] T_MAG = 4'd11;  // round and clamp the sine
  localparam logic [3:0] T_ML  = 4'd12;  // magnitude * level
  localparam logic [3:0] T_MG  = 4'd13;  // * gain
  localparam logic [3:0] T_RND = 4'd14;  // round the sample, start decay
  localparam logic [3:0] T_FIN = 4'd15;  // commit and emit

  state_t                   state_r, state_nxt;
  logic [3:0]               st_r, st_nxt;
  logic [SR_W-1:0]          sr_r, sr_nxt;
  logic [PHASE_BITS-1:0]    phase_r, phase_nxt;
  logic [PHASE_BITS-1:0]    step_r, step_nxt;
  logic [LEVEL_W-1:0]       level_r, level_nxt;
  logic [GAIN_W-1:0]        gain_r, gain_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [NOTE_W-1:0]        note_r, note_nxt;
  logic [VEL_W-1:0]         vel_r, vel_nxt;
  logic [Q30_W-1:0]         x_r, x_nxt;
  logic [Q30_W-1:0]         x2_r, x2_nxt;
  logic [Q30_W-1:0]         t_r, t_nxt;
  logic                     neg_r, neg_nxt;
  logic [MAG_W-1:0]         m_r, m_nxt;
  logic [SAMPLE_BITS-1:0]   r_r, r_nxt;
  logic [SAMPLE_BITS-1:0]   out_sample_r, out_sample_nxt;
  logic                     out_active_r, out_active_nxt;

  logic                     accept;
  logic                     out_free;

  // Sine argument from the phase
  logic [IDX_BITS-1:0]      idx;
  logic [1:0]               quad;
  logic [IDX_BITS-3:0]      frac;
  logic [Q30_W-1:0]         x0;
  logic [Q30_W-1:0]         x_calc;

  // Note-on operands
  logic [OCT_W-1:0]         oct;
  logic [OCT_W-1:0]         pc;
  logic [FREQ_W-1:0]        freq;
  logic [SR_W-1:0]          sr_eff;
  logic [DIV_W-1:0]         step_dividend;
  logic [LVL_NUM_W-1:0]     lvl_num;
  logic [PHASE_BITS-1:0]    q_step;

  // Divider and multiplier hookup
  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [SR_W-1:0]          div_divisor;
  logic [CNT_W-1:0]         div_steps;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quo;
  logic [MA_W-1:0]          mul_a;
  logic [MB_W-1:0]          mul_b;
  logic [MP_W-1:0]          mul_p;

  // Product taps
  logic [Q30_W-1:0]         pq30;
  logic [SUM_W-1:0]         s_sum;
  logic [SUM_W-1:0]         qv;
  logic [MAG_W-1:0]         mag;
  logic [GAIN_W-1:0]        g_eff;
  logic [MP_W-1:0]          rsum;
  logic [SAMPLE_BITS-1:0]   r_abs;
  logic [SAMPLE_BITS-1:0]   r_val;
  logic [MP_W-1:0]          dsum;
  logic [GAIN_W-1:0]        ng;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Fold the table index into a quarter wave
  assign idx    = phase_r[PHASE_BITS-1 -: IDX_BITS];
  assign quad   = idx[IDX_BITS-1 -: 2];
  assign frac   = idx[IDX_BITS-3:0];
  assign x0     = Q30_W'(frac) << (32 - IDX_BITS);
  assign x_calc = quad[0] ? (Q30_ONE - x0) : x0;

  // Phase step dividend: (freq << (PHASE_BITS-16)) + rate/2
  assign oct           = note_octave(note_r);
  assign pc            = note_class(note_r, oct);
  assign freq          = FREQ_W'(octave_base(pc)) << oct;
  assign sr_eff        = (sr_r == '0) ? SR_W'(1) : sr_r;
  assign step_dividend = (DIV_W'(freq) << (PHASE_BITS - 16)) + DIV_W'(sr_eff >> 1);
  assign q_step        = div_quo[PHASE_BITS-1:0];

  // Level numerator, scaled by the reciprocal of 1270 in the multiplier
  assign lvl_num = 24'(vel_r) * LVL_SCALE + LVL_BIAS;

  // Product taps for each micro-step
  assign pq30  = mul_p[30 +: Q30_W];
  assign s_sum = SUM_W'(pq30) + (SUM_W'(1) << (30 - SAMPLE_BITS));
  assign qv    = s_sum >> (31 - SAMPLE_BITS);
  assign mag   = (qv > SUM_W'(MAG_MAX)) ? MAG_MAX : qv[MAG_W-1:0];
  assign g_eff = (gain_r == '0) ? GAIN_ONE : gain_r;
  assign rsum  = mul_p + (MP_W'(1) << 31);
  assign r_abs = rsum[32 +: SAMPLE_BITS];
  assign r_val = neg_r ? (SAMPLE_BITS'(0) - r_abs) : r_abs;
  assign dsum  = mul_p + MP_W'(32768);
  assign ng    = dsum[16 +: GAIN_W];

  // Select multiplier operands: level scaling outside a tick, micro-steps inside
  always_comb begin
    mul_a = MA_W'(lvl_num);
    mul_b = MB_W'(LVL_RECIP);
    if (state_r == S_TICK) begin
      case (st_r)
        T_SQ: begin
          mul_a = MA_W'(x_r);
          mul_b = x_r;
        end
        T_M0: begin
          mul_a = MA_W'(x2_r);
          mul_b = POLY_C0;
        end
        T_M1, T_M2, T_M3: begin
          mul_a = MA_W'(x2_r);
          mul_b = t_r;
        end
        T_MX: begin
          mul_a = MA_W'(x_r);
          mul_b = t_r;
        end
        T_ML: begin
          mul_a = MA_W'(m_r);
          mul_b = MB_W'(level_r);
        end
        T_MG: begin
          mul_a = mul_p[MA_W-1:0];
          mul_b = MB_W'(g_eff);
        end
        default: begin
          mul_a = MA_W'(gain_r);
          mul_b = MB_W'(DECAY_Q16);
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    sr_nxt         = sr_r;
    phase_nxt      = phase_r;
    step_nxt       = step_r;
    level_nxt      = level_r;
    gain_nxt       = gain_r;
    out_valid_nxt  = out_valid_r;
    note_nxt       = note_r;
    vel_nxt        = vel_r;
    x_nxt          = x_r;
    x2_nxt         = x2_r;
    t_nxt          = t_r;
    neg_nxt        = neg_r;
    m_nxt          = m_r;
    r_nxt          = r_r;
    out_sample_nxt = out_sample_r;
    out_active_nxt = out_active_r;
    div_start      = 1'b0;
    div_dividend   = step_dividend;
    div_divisor    = sr_eff;
    div_steps      = CNT_W'(DIV_W);

    if (cfg_valid) begin
      sr_nxt = cfg_sample_rate_hz;
    end

    // Drop the output item once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_NOTE_ON: begin
              note_nxt  = in_note;
              vel_nxt   = in_velocity;
              state_nxt = S_NOTE;
            end
            CMD_NOTE_OFF: begin
              if (in_allow_tail_off && (gain_r == '0)) begin
                gain_nxt = GAIN_ONE;
              end else begin
                step_nxt = '0;
                gain_nxt = '0;
              end
            end
            CMD_TICK: begin
              x_nxt     = x_calc;
              neg_nxt   = quad[1];
              st_nxt    = T_SQ;
              state_nxt = S_TICK;
            end
            default: ;
          endcase
        end
      end

      S_NOTE: begin
        div_start = 1'b1;
        state_nxt = S_DSTEP;
      end

      // Commit step and level, and clear phase and gain, once the divider finishes
      S_DSTEP: begin
        if (div_done) begin
          step_nxt  = (q_step == '0) ? PHASE_BITS'(1) : q_step;
          level_nxt = mul_p[LVL_SHIFT +: LEVEL_W];
          phase_nxt = '0;
          gain_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end

      S_TICK: begin
        if (st_r != T_FIN) begin
          st_nxt = st_r + 4'd1;
        end
        case (st_r)
          T_X2:  x2_nxt = pq30;
          T_S1:  t_nxt  = POLY_C1 - pq30;
          T_S2:  t_nxt  = POLY_C2 - pq30;
          T_S3:  t_nxt  = POLY_C3 - pq30;
          T_S4:  t_nxt  = POLY_C4 - pq30;
          T_MAG: m_nxt  = mag;
          T_RND: r_nxt  = r_val;
          T_FIN: begin
            // Hold until the output register is free
            if (out_free) begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
              if (step_r != '0) begin
                out_sample_nxt = r_r;
                out_active_nxt = 1'b1;
                phase_nxt      = phase_r + step_r;
                if (gain_r != '0) begin
                  gain_nxt = ng;
                  if (ng <= STOP_FLOOR) begin
                    step_nxt = '0;
                    gain_nxt = '0;
                  end
                end
              end else begin
                out_sample_nxt = '0;
                out_active_nxt = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= T_SQ;
      sr_r        <= SR_RESET;
      phase_r     <= '0;
      step_r      <= '0;
      level_r     <= '0;
      gain_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      sr_r        <= sr_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      level_r     <= level_nxt;
      gain_r      <= gain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and output payload
  always_ff @(posedge clk) begin
    note_r       <= note_nxt;
    vel_r        <= vel_nxt;
    x_r          <= x_nxt;
    x2_r         <= x2_nxt;
    t_r          <= t_nxt;
    neg_r        <= neg_nxt;
    m_r          <= m_nxt;
    r_r          <= r_nxt;
    out_sample_r <= out_sample_nxt;
    out_active_r <= out_active_nxt;
  end

  svoice_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (SR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quo)
  );

  svoice_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_active = out_active_r;

endmodule

// ===== rtl/svoice_chk.sv =====
`timescale 1ns / 1ps

module svoice_chk #(
  parameter int SAMPLE_BITS = svoice_pkg::DEF_SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [svoice_pkg::CMD_W-1:0]  in_cmd,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [SAMPLE_BITS-1:0]        out_sample,
  input logic                          out_active
);

  import svoice_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_active))
    else $error("stalled result changed");

  // Silent voice gives a zero sample
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> out_sample == '0)
    else $error("idle tick with nonzero sample");

  // Note on and tick occupy the sequencer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_NOTE_ON || in_cmd == CMD_TICK) |=> !in_ready)
    else $error("ready right after a multi-cycle item");

  // Reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind sine_voice_with_tail_off svoice_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_svoice_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_cmd     (in_cmd),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample),
  .out_active (out_active)
);

// ===== test/sine_voice_with_tail_off_test.sv =====
`timescale 1ns / 1ps

module sine_voice_with_tail_off_test;
  import svoice_pkg::*;

  localparam int TABLE_DEPTH = DEF_SINE_TABLE_DEPTH;
  localparam int PH_BITS     = DEF_PHASE_BITS;
  localparam int SMP_BITS    = DEF_SAMPLE_BITS;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES     = 120;
  localparam int CYCLE_LIMIT       = 1000000;
  localparam int ITEMS_PER_SETTING = 170;

  localparam logic [63:0] PH_MASK = (64'd1 << PH_BITS) - 64'd1;

  // Q16 frequencies of the twelve pitch classes in the lowest octave, class 0 lowest
  localparam logic [12*20-1:0] PITCH_Q16 = {
    20'd1011473, 20'd954703, 20'd901120, 20'd850544, 20'd802807, 20'd757749,
    20'd715219,  20'd675077, 20'd637188, 20'd601425, 20'd567670, 20'd535809
  };

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic              tail;
  } voice_cmd_t;

  typedef struct packed {
    logic signed [SMP_BITS-1:0] sample;
    logic                       active;
  } voice_out_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [SR_W-1:0]            cfg_sample_rate_hz = SR_RESET;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CMD_W-1:0]           in_cmd = CMD_TICK;
  logic [NOTE_W-1:0]          in_note = '0;
  logic [VEL_W-1:0]           in_velocity = '0;
  logic                       in_allow_tail_off = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SMP_BITS-1:0] out_sample;
  logic                       out_active;

  // Voice state as the block should hold it
  logic [SR_W-1:0] sample_rate = SR_RESET;
  logic [63:0]     voice_phase = '0;
  logic [63:0]     voice_step = '0;
  logic [63:0]     voice_level = '0;
  logic [63:0]     voice_gain = '0;

  voice_cmd_t pending_cmds[$];
  voice_out_t expected_samples[$];

  int  queued_total = 0;
  int  accepted_total = 0;
  int  items_this_setting = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  idle_pct = 0;
  bit  quiet = 1'b0;
  bit  in_taken = 1'b0;
  int  send_hold = 0;
  int  stall_left = 0;

  sine_voice_with_tail_off DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_sample_rate_hz (cfg_sample_rate_hz),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_note            (in_note),
    .in_velocity        (in_velocity),
    .in_allow_tail_off  (in_allow_tail_off),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample         (out_sample),
    .out_active         (out_active)
  );

  always #5 clk = ~clk;

  // sin(pi/2 * x) for x in Q30 over [0, 1], truncating products
  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
    logic [63:0] x2, t;
    x2 = (x * x) >> 30;
    t = 64'(POLY_C1) - ((x2 * 64'(POLY_C0)) >> 30);
    t = 64'(POLY_C2) - ((x2 * t) >> 30);
    t = 64'(POLY_C3) - ((x2 * t) >> 30);
    t = 64'(POLY_C4) - ((x2 * t) >> 30);
    return (x * t) >> 30;
  endfunction

  // Fold the phase into a quarter wave and round the sine to the sample format
  function automatic logic [63:0] sine_magnitude(input logic [63:0] ph, output logic neg);
    logic [63:0] idx, quad, rem, x, s, q, top;
    idx = (ph * 64'(TABLE_DEPTH)) >> PH_BITS;
    quad = (idx * 64'd4) / 64'(TABLE_DEPTH);
    rem = idx * 64'd4 - quad * 64'(TABLE_DEPTH);
    x = (rem << 30) / 64'(TABLE_DEPTH);
    if (quad[0]) begin
      x = 64'(Q30_ONE) - x;
    end
    neg = quad[1];
    s = quarter_sine_q30(x);
    q = (s + (64'd1 << (30 - SMP_BITS))) >> (31 - SMP_BITS);
    top = (64'd1 << (SMP_BITS - 1)) - 64'd1;
    return (q > top) ? top : q;
  endfunction

  // Advance the voice by one accepted item; queue the tick result it makes
  task automatic advance_voice(input voice_cmd_t c);
    logic [63:0] sr, freq, st, mag, gain, scaled;
    logic        neg;
    int          pc, oct;
    voice_out_t  r;
    case (c.cmd)
      CMD_NOTE_ON: begin
        sr = (sample_rate == '0) ? 64'd1 : 64'(sample_rate);
        pc = c.note % 12;
        oct = c.note / 12;
        freq = 64'(PITCH_Q16[pc*20 +: 20]) << oct;
        st = (((freq << (PH_BITS - 16)) + sr / 64'd2) / sr) & PH_MASK;
        voice_phase = '0;
        voice_level = (64'(c.vel) * 64'(LVL_SCALE) + 64'(LVL_BIAS)) / 64'(LVL_DIVISOR);
        voice_gain = '0;
        voice_step = (st == '0) ? 64'd1 : st;
      end
      CMD_NOTE_OFF: begin
        // a second tail-off or a hard off silences the voice
        if (c.tail && voice_gain == '0) begin
          voice_gain = 64'(GAIN_ONE);
        end else begin
          voice_step = '0;
          voice_gain = '0;
        end
      end
      CMD_TICK: begin
        r.sample = '0;
        r.active = 1'b0;
        if (voice_step != '0) begin
          mag = sine_magnitude(voice_phase, neg);
          gain = (voice_gain != '0) ? voice_gain : 64'(GAIN_ONE);
          scaled = (mag * voice_level * gain + (64'd1 << 31)) >> 32;
          r.sample = neg ? SMP_BITS'(-scaled) : SMP_BITS'(scaled);
          r.active = 1'b1;
          voice_phase = (voice_phase + voice_step) & PH_MASK;
          // decay the release and stop once it falls to the floor
          if (voice_gain != '0) begin
            voice_gain = (voice_gain * 64'(DECAY_Q16) + 64'd32768) >> 16;
            if (voice_gain <= 64'(STOP_FLOOR)) begin
              voice_step = '0;
              voice_gain = '0;
            end
          end
        end
        expected_samples.push_back(r);
      end
      default: begin
        // unknown command: ignored
      end
    endcase
  endtask

  // Check results, then track configuration and accepted items
  always @(posedge clk) begin : check_and_track
    voice_out_t want;
    cycle_count = cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
          $display("%0t: sample %0d active %0b arrived with no tick waiting",
                   $time, out_sample, out_active);
        end
      end else begin
        want = expected_samples.pop_front();
        if (out_sample !== want.sample || out_active !== want.active) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("%0t: expected sample %0d active %0b, got sample %0d active %0b",
                     $time, want.sample, want.active, out_sample, out_active);
          end
        end
      end
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      sample_rate = cfg_sample_rate_hz;
    end
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      accepted_total = accepted_total + 1;
      advance_voice('{cmd: in_cmd, note: in_note, vel: in_velocity, tail: in_allow_tail_off});
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive pending items, holding each until taken, with random gaps between them
  always @(negedge clk) begin : send_items
    voice_cmd_t next_cmd;
    if (!in_valid || in_taken) begin
      if (send_hold > 0) begin
        send_hold <= send_hold - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_cmd <= next_cmd.cmd;
        in_note <= next_cmd.note;
        in_velocity <= next_cmd.vel;
        in_allow_tail_off <= next_cmd.tail;
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
          send_hold <= $urandom_range(1, 17);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [NOTE_W-1:0] note,
                            input logic [VEL_W-1:0] vel, input logic tail);
    voice_cmd_t c;
    c.cmd = cmd;
    c.note = note;
    c.vel = vel;
    c.tail = tail;
    pending_cmds.push_back(c);
    queued_total = queued_total + 1;
    if (cmd != CMD_UNUSED) begin
      items_this_setting = items_this_setting + 1;
    end
  endtask

  task automatic queue_ticks(input int count);
    repeat (count) queue_item(CMD_TICK, NOTE_W'($urandom), VEL_W'($urandom), 1'($urandom));
  endtask

  // One musical phrase (note on, some ticks, then one way of ending it) or a burst of noise.
  // A ring-out phrase lets the release decay until the voice stops by itself.
  task automatic queue_phrase(input bit ring_out);
    int shape;
    shape = $urandom_range(0, 99);
    if (!ring_out && shape < 15) begin
      // noise: any command with any fields
      repeat ($urandom_range(1, 8)) queue_item(CMD_W'($urandom_range(0, 3)),
                                               NOTE_W'($urandom), VEL_W'($urandom),
                                               1'($urandom));
    end else begin
      queue_item(CMD_NOTE_ON, NOTE_W'($urandom),
                 ring_out ? VEL_W'($urandom_range(96, 127)) : VEL_W'($urandom),
                 1'($urandom));
      queue_ticks($urandom_range(1, 24));
      if (ring_out) begin
        queue_item(CMD_NOTE_OFF, NOTE_W'($urandom), VEL_W'($urandom), 1'b1);
        queue_ticks($urandom_range(540, 580));
      end else begin
        case (shape % 5)
          0: begin
            queue_item(CMD_NOTE_OFF, NOTE_W'($urandom), VEL_W'($urandom), 1'b1);
            queue_ticks($urandom_range(1, 30));
          end
          1: begin
            queue_item(CMD_NOTE_OFF, NOTE_W'($urandom), VEL_W'($urandom), 1'b1);
            queue_ticks($urandom_range(0, 8));
            queue_item(CMD_NOTE_OFF, NOTE_W'($urandom), VEL_W'($urandom), 1'b1);
            queue_ticks($urandom_range(1, 4));
          end
          2: begin
            queue_item(CMD_NOTE_OFF, NOTE_W'($urandom), VEL_W'($urandom), 1'b0);
            queue_ticks($urandom_range(1, 4));
          end
          3: begin
            // leave the note sounding; the next note on retriggers it
          end
          default: begin
            queue_item(CMD_NOTE_OFF, NOTE_W'($urandom), VEL_W'($urandom), 1'b1);
            queue_ticks($urandom_range(0, 6));
            queue_item(CMD_NOTE_OFF, NOTE_W'($urandom), VEL_W'($urandom), 1'b0);
            queue_ticks($urandom_range(1, 3));
          end
        endcase
      end
    end
  endtask

  // Wait until every item is taken and every result checked, then let a
  // note on still in progress finish
  task automatic wait_for_quiet_voice();
    do @(negedge clk); while (accepted_total != queued_total || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_sample_rate(input logic [SR_W-1:0] hz);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_sample_rate_hz <= hz;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [SR_W-1:0] hz;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 20;

    // Directed: idle voice, field extremes, every command, release and stops
    queue_item(CMD_TICK, 7'd127, 7'd127, 1'b1);
    queue_item(CMD_NOTE_OFF, 7'd0, 7'd0, 1'b1);
    queue_item(CMD_TICK, 7'd0, 7'd0, 1'b0);
    queue_item(CMD_NOTE_ON, 7'd127, 7'd127, 1'b0);
    queue_ticks(3);
    queue_item(CMD_UNUSED, 7'd127, 7'd127, 1'b1);
    queue_item(CMD_TICK, 7'd0, 7'd0, 1'b0);
    queue_item(CMD_NOTE_ON, 7'd0, 7'd0, 1'b1);
    queue_ticks(2);
    queue_item(CMD_NOTE_ON, 7'd69, 7'd127, 1'b0);
    queue_ticks(2);
    queue_item(CMD_NOTE_OFF, 7'd0, 7'd0, 1'b1);
    queue_ticks(2);
    queue_item(CMD_NOTE_OFF, 7'd127, 7'd127, 1'b1);
    queue_item(CMD_TICK, 7'd0, 7'd0, 1'b0);
    queue_item(CMD_NOTE_ON, 7'd60, 7'd64, 1'b1);
    queue_item(CMD_TICK, 7'd0, 7'd0, 1'b0);
    queue_item(CMD_NOTE_OFF, 7'd127, 7'd127, 1'b0);
    queue_item(CMD_TICK, 7'd0, 7'd0, 1'b0);

    // Random phrases at the reset rate, starting with one full ring-out
    items_this_setting = 0;
    queue_phrase(1'b1);
    while (items_this_setting < ITEMS_PER_SETTING + 550) queue_phrase(1'b0);
    wait_for_quiet_voice();

    for (int s = 0; s < 6; s++) begin
      case (s)
        0:       hz = 18'd8000;
        1:       hz = 18'd192000;
        2:       hz = 18'd0;
        3:       hz = 18'h3FFFF;
        4:       hz = SR_W'($urandom_range(8000, 192000));
        default: hz = 18'd44100;
      endcase
      write_sample_rate(hz);
      quiet = (s == 5);
      idle_pct = quiet ? 0 : $urandom_range(0, 35);
      items_this_setting = 0;
      if (hz == '0) begin
        // a rate of zero acts as one; A notes then wrap to a zero step
        queue_item(CMD_NOTE_ON, 7'd69, 7'd127, 1'b0);
        queue_ticks(3);
        queue_item(CMD_NOTE_ON, 7'd33, 7'd100, 1'b0);
        queue_ticks(2);
        queue_item(CMD_NOTE_ON, 7'd70, 7'd127, 1'b0);
        queue_ticks(2);
      end
      while (items_this_setting < ITEMS_PER_SETTING) queue_phrase(1'b0);
      wait_for_quiet_voice();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
